// ===== sv/segment_color_averager_assert.svh =====
// assertion macros used by the checker file sca_checker.sv
`ifndef SEGMENT_COLOR_AVERAGER_ASSERT_SVH
`define SEGMENT_COLOR_AVERAGER_ASSERT_SVH

// same-cycle implication under synchronous reset
`define SCA_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication under synchronous reset
`define SCA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/sca_pkg.sv =====
`timescale 1ns / 1ps
package sca_pkg;

  // field and state widths
  localparam int SEGMENTS_DEF = 20;
  localparam int SEG_IDX_W    = 6;
  localparam int COLOR_W      = 8;
  localparam int SUM_W        = 32;
  localparam int COUNT_W      = 24;
  localparam int WORD_W       = 3 * SUM_W;
  localparam int COL_W        = 12;
  localparam int LINE_W       = 11;
  localparam int FW_W         = 13;
  localparam int FL_W         = 11;
  localparam int STEP_W       = 7;
  localparam int SW_W         = 13;
  localparam int CFG_IDX_W    = 3;
  localparam int CFG_DATA_W   = 13;

  // register reset values and limits
  localparam logic [FW_W-1:0]   FW_RST    = 13'd1920;
  localparam logic [FL_W-1:0]   FL_RST    = 11'd360;
  localparam logic [STEP_W-1:0] CSTEP_RST = 7'd4;
  localparam logic [STEP_W-1:0] RSTEP_RST = 7'd10;
  localparam logic [SW_W-1:0]   SW_RST    = 13'd96;
  localparam logic [FW_W-1:0]   MAX_WIDTH = 13'd4096;

  // register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FRAME_WIDTH,
    REG_FRAME_LINES,
    REG_COLUMN_STEP,
    REG_ROW_STEP,
    REG_SEGMENT_WIDTH
  } sca_reg_t;

  // controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ACC,
    ST_DR_READ,
    ST_DR_START,
    ST_DR_WAIT,
    ST_RC_START,
    ST_RC_WAIT
  } sca_state_t;

  // sum memory command
  typedef struct packed {
    logic rd_en;
    logic wr_en;
    logic clr_en;
  } sca_mem_cmd_t;

endpackage

// ===== sv/segment_color_averager.sv =====
`timescale 1ns / 1ps
// Segment color averager: raster pixel stream in, one average per segment out.
// Input channel (in_valid/in_ready) carries one pixel per request with its
// red, green and blue bytes and a start_of_frame flag that moves the position
// back to column 0, line 0. The block tracks column and line itself.
// A pixel that is not a sample is taken in ST_IDLE; for a sample ST_IDLE reads
// its segment entry in the sum memory and ST_ACC writes back the new sums.
// After the last pixel of a frame the block sends SEGMENTS result requests in
// segment order on out_valid/out_ready. Each result comes from the 32-step
// bit-serial dividers (one per color), which divide each sum by the segment 0
// sample count. Pixels are not taken while results are formed; the last
// result sits in the output register while pixels flow again.
// A stalled receiver holds the current result and stops the next one.
// Configuration requests (cfg_valid/cfg_ready, always ready) write one
// register; the next pixel then waits while the dividers recompute the
// sampling phases and segment of the current position.
// Reset loads the default register values, puts the position at column 0,
// line 0 and clears the sums at once through per-entry valid bits.
module segment_color_averager #(
  parameter int SEGMENTS = sca_pkg::SEGMENTS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [sca_pkg::COLOR_W-1:0]    in_pixel_red,
  input  logic [sca_pkg::COLOR_W-1:0]    in_pixel_green,
  input  logic [sca_pkg::COLOR_W-1:0]    in_pixel_blue,
  input  logic                          in_start_of_frame,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [sca_pkg::SEG_IDX_W-1:0]  out_segment_index,
  output logic [sca_pkg::COLOR_W-1:0]    out_red_average,
  output logic [sca_pkg::COLOR_W-1:0]    out_green_average,
  output logic [sca_pkg::COLOR_W-1:0]    out_blue_average,
  output logic                          out_last_segment,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [sca_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [sca_pkg::CFG_DATA_W-1:0] cfg_data
);
  import sca_pkg::*;

  localparam int SEG_AW = (SEGMENTS > 1) ? $clog2(SEGMENTS) : 1;
  localparam logic [SEG_AW-1:0] LAST_SEG = SEG_AW'(SEGMENTS - 1);

  // configuration registers
  logic [FW_W-1:0]   frame_width_r;
  logic [FL_W-1:0]   frame_lines_r;
  logic [STEP_W-1:0] column_step_r;
  logic [STEP_W-1:0] row_step_r;
  logic [SW_W-1:0]   segment_width_r;
  logic              cfg_fire;

  assign cfg_ready = 1'b1;
  assign cfg_fire  = cfg_valid & cfg_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_width_r   <= FW_RST;
      frame_lines_r   <= FL_RST;
      column_step_r   <= CSTEP_RST;
      row_step_r      <= RSTEP_RST;
      segment_width_r <= SW_RST;
    end else if (cfg_fire) begin
      case (cfg_index)
        REG_FRAME_WIDTH:   frame_width_r   <= cfg_data[FW_W-1:0];
        REG_FRAME_LINES:   frame_lines_r   <= cfg_data[FL_W-1:0];
        REG_COLUMN_STEP:   column_step_r   <= cfg_data[STEP_W-1:0];
        REG_ROW_STEP:      row_step_r      <= cfg_data[STEP_W-1:0];
        REG_SEGMENT_WIDTH: segment_width_r <= cfg_data[SW_W-1:0];
        default: ;
      endcase
    end
  end

  // effective values: zero acts as one, width capped
  logic [FW_W-1:0]   width_eff;
  logic [FL_W-1:0]   lines_eff;
  logic [STEP_W-1:0] cstep_eff;
  logic [STEP_W-1:0] rstep_eff;
  logic [SW_W-1:0]   swidth_eff;

  always_comb begin
    if (frame_width_r == '0) begin
      width_eff = FW_W'(1);
    end else if (frame_width_r > MAX_WIDTH) begin
      width_eff = MAX_WIDTH;
    end else begin
      width_eff = frame_width_r;
    end
    lines_eff  = (frame_lines_r == '0) ? FL_W'(1) : frame_lines_r;
    cstep_eff  = (column_step_r == '0) ? STEP_W'(1) : column_step_r;
    rstep_eff  = (row_step_r == '0) ? STEP_W'(1) : row_step_r;
    swidth_eff = (segment_width_r == '0) ? SW_W'(1) : segment_width_r;
  end

  // controller and position state
  sca_state_t        state_r, state_nxt;
  logic [COL_W-1:0]  col_r, col_nxt;
  logic [LINE_W-1:0] line_r, line_nxt;
  logic [STEP_W-1:0] col_ph_r, col_ph_nxt;
  logic [STEP_W-1:0] line_ph_r, line_ph_nxt;
  logic [COL_W-1:0]  off_r, off_nxt;
  logic [SEG_AW-1:0] seg_r, seg_nxt;
  logic              pend_r, pend_nxt;
  logic [COUNT_W-1:0] count_r, count_nxt;
  logic [SEG_AW-1:0] idx_r, idx_nxt;
  logic [SEG_AW-1:0] acc_seg_r, acc_seg_nxt;
  logic              fe_r, fe_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic              out_load;
  logic              in_ready_c;

  // payload registers
  logic [COLOR_W-1:0]   px_red_r, px_green_r, px_blue_r;
  logic [SEG_IDX_W-1:0] out_idx_r;
  logic [COLOR_W-1:0]   out_red_r, out_green_r, out_blue_r;
  logic                 out_last_r;

  // memory and divider hookup
  sca_mem_cmd_t       mem_cmd;
  logic [SEG_AW-1:0]  rd_addr, wr_addr;
  logic [WORD_W-1:0]  wr_data, rd_data;
  logic               div_start;
  logic [2:0]         div_busy;
  logic               div_any_busy;
  logic [SUM_W-1:0]   div_dividend [3];
  logic [COUNT_W-1:0] div_divisor [3];
  logic [SUM_W-1:0]   div_quo [3];
  logic [COUNT_W-1:0] div_rem [3];

  assign div_any_busy = |div_busy;

  // position of the offered pixel after start of frame
  logic [COL_W-1:0]  cur_col;
  logic [LINE_W-1:0] cur_line;
  logic [STEP_W-1:0] cur_col_ph, cur_line_ph;
  logic [COL_W-1:0]  cur_off;
  logic [SEG_AW-1:0] cur_seg;
  logic              sample, line_end, frame_end;

  always_comb begin
    cur_col     = in_start_of_frame ? '0 : col_r;
    cur_line    = in_start_of_frame ? '0 : line_r;
    cur_col_ph  = in_start_of_frame ? '0 : col_ph_r;
    cur_line_ph = in_start_of_frame ? '0 : line_ph_r;
    cur_off     = in_start_of_frame ? '0 : off_r;
    cur_seg     = in_start_of_frame ? '0 : seg_r;
    sample      = (cur_col_ph == '0) && (cur_line_ph == '0);
    line_end    = ({1'b0, cur_col} + FW_W'(1)) >= width_eff;
    frame_end   = line_end && (({1'b0, cur_line} + (LINE_W+1)'(1)) >= {1'b0, lines_eff});
  end

  // sums plus the held pixel
  assign wr_data = {rd_data[WORD_W-1:2*SUM_W] + SUM_W'(px_red_r),
                    rd_data[2*SUM_W-1:SUM_W] + SUM_W'(px_green_r),
                    rd_data[SUM_W-1:0] + SUM_W'(px_blue_r)};

  // divider operands: position in ST_RC_START, sums over count otherwise
  always_comb begin
    if (state_r == ST_RC_START) begin
      div_dividend[0] = SUM_W'(col_r);
      div_divisor[0]  = COUNT_W'(cstep_eff);
      div_dividend[1] = SUM_W'(col_r);
      div_divisor[1]  = COUNT_W'(swidth_eff);
      div_dividend[2] = SUM_W'(line_r);
      div_divisor[2]  = COUNT_W'(rstep_eff);
    end else begin
      div_dividend[0] = rd_data[WORD_W-1:2*SUM_W];
      div_divisor[0]  = count_r;
      div_dividend[1] = rd_data[2*SUM_W-1:SUM_W];
      div_divisor[1]  = count_r;
      div_dividend[2] = rd_data[SUM_W-1:0];
      div_divisor[2]  = count_r;
    end
  end

  // next state and controls
  always_comb begin
    state_nxt   = state_r;
    col_nxt     = col_r;
    line_nxt    = line_r;
    col_ph_nxt  = col_ph_r;
    line_ph_nxt = line_ph_r;
    off_nxt     = off_r;
    seg_nxt     = seg_r;
    pend_nxt    = pend_r | cfg_fire;
    count_nxt   = count_r;
    idx_nxt     = idx_r;
    acc_seg_nxt = acc_seg_r;
    fe_nxt      = fe_r;
    mem_cmd     = '0;
    rd_addr     = idx_r;
    wr_addr     = acc_seg_r;
    div_start   = 1'b0;
    out_load    = 1'b0;
    in_ready_c  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (pend_r) begin
          pend_nxt  = cfg_fire;
          state_nxt = ST_RC_START;
        end else begin
          in_ready_c = 1'b1;
          if (in_valid) begin
            // advance the position
            if (frame_end) begin
              col_nxt     = '0;
              line_nxt    = '0;
              col_ph_nxt  = '0;
              line_ph_nxt = '0;
              off_nxt     = '0;
              seg_nxt     = '0;
            end else if (line_end) begin
              col_nxt     = '0;
              col_ph_nxt  = '0;
              off_nxt     = '0;
              seg_nxt     = '0;
              line_nxt    = LINE_W'(cur_line + 1'b1);
              line_ph_nxt = (cur_line_ph == STEP_W'(rstep_eff - 1'b1)) ? '0 :
                            STEP_W'(cur_line_ph + 1'b1);
              seg_nxt     = '0;
            end else begin
              col_nxt     = COL_W'(cur_col + 1'b1);
              line_nxt    = cur_line;
              line_ph_nxt = cur_line_ph;
              col_ph_nxt  = (cur_col_ph == STEP_W'(cstep_eff - 1'b1)) ? '0 :
                            STEP_W'(cur_col_ph + 1'b1);
              if ({1'b0, cur_off} == SW_W'(swidth_eff - 1'b1)) begin
                off_nxt = '0;
                seg_nxt = (cur_seg == LAST_SEG) ? cur_seg : SEG_AW'(cur_seg + 1'b1);
              end else begin
                off_nxt = COL_W'(cur_off + 1'b1);
                seg_nxt = cur_seg;
              end
            end
            // samples go through the sum memory
            if (sample) begin
              mem_cmd.rd_en = 1'b1;
              rd_addr       = cur_seg;
              acc_seg_nxt   = cur_seg;
              fe_nxt        = frame_end;
              state_nxt     = ST_ACC;
            end else if (frame_end) begin
              idx_nxt   = '0;
              state_nxt = ST_DR_READ;
            end
          end
        end
      end
      ST_ACC: begin
        mem_cmd.wr_en = 1'b1;
        if (acc_seg_r == '0) begin
          count_nxt = COUNT_W'(count_r + 1'b1);
        end
        idx_nxt   = '0;
        state_nxt = fe_r ? ST_DR_READ : ST_IDLE;
      end
      ST_DR_READ: begin
        // read the entry and clear it for the next frame
        mem_cmd.rd_en  = 1'b1;
        mem_cmd.clr_en = 1'b1;
        state_nxt      = ST_DR_START;
      end
      ST_DR_START: begin
        div_start = 1'b1;
        state_nxt = ST_DR_WAIT;
      end
      ST_DR_WAIT: begin
        if (!div_any_busy && (!out_valid_r || out_ready)) begin
          out_load = 1'b1;
          if (idx_r == LAST_SEG) begin
            count_nxt = '0;
            state_nxt = ST_IDLE;
          end else begin
            idx_nxt   = SEG_AW'(idx_r + 1'b1);
            state_nxt = ST_DR_READ;
          end
        end
      end
      ST_RC_START: begin
        div_start = 1'b1;
        state_nxt = ST_RC_WAIT;
      end
      ST_RC_WAIT: begin
        // phases and segment of the current position
        if (!div_any_busy) begin
          col_ph_nxt  = div_rem[0][STEP_W-1:0];
          off_nxt     = div_rem[1][COL_W-1:0];
          seg_nxt     = (div_quo[1] > SUM_W'(SEGMENTS - 1)) ? LAST_SEG :
                        div_quo[1][SEG_AW-1:0];
          line_ph_nxt = div_rem[2][STEP_W-1:0];
          state_nxt   = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // output valid
  always_comb begin
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      col_r       <= '0;
      line_r      <= '0;
      col_ph_r    <= '0;
      line_ph_r   <= '0;
      off_r       <= '0;
      seg_r       <= '0;
      pend_r      <= 1'b0;
      count_r     <= '0;
      idx_r       <= '0;
      acc_seg_r   <= '0;
      fe_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      col_r       <= col_nxt;
      line_r      <= line_nxt;
      col_ph_r    <= col_ph_nxt;
      line_ph_r   <= line_ph_nxt;
      off_r       <= off_nxt;
      seg_r       <= seg_nxt;
      pend_r      <= pend_nxt;
      count_r     <= count_nxt;
      idx_r       <= idx_nxt;
      acc_seg_r   <= acc_seg_nxt;
      fe_r        <= fe_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // saturated average, zero for an empty count
  function automatic logic [COLOR_W-1:0] sat_avg(input logic [SUM_W-1:0] quo,
                                                 input logic [COUNT_W-1:0] cnt);
    logic [COLOR_W-1:0] res;
    if (cnt == '0) begin
      res = '0;
    end else if (|quo[SUM_W-1:COLOR_W]) begin
      res = '1;
    end else begin
      res = quo[COLOR_W-1:0];
    end
    return res;
  endfunction

  // pixel and result payload
  always_ff @(posedge clk) begin
    if (in_valid && in_ready_c) begin
      px_red_r   <= in_pixel_red;
      px_green_r <= in_pixel_green;
      px_blue_r  <= in_pixel_blue;
    end
    if (out_load) begin
      out_idx_r   <= SEG_IDX_W'(idx_r);
      out_red_r   <= sat_avg(div_quo[0], count_r);
      out_green_r <= sat_avg(div_quo[1], count_r);
      out_blue_r  <= sat_avg(div_quo[2], count_r);
      out_last_r  <= (idx_r == LAST_SEG);
    end
  end

  sca_sum_mem #(
    .SEGMENTS (SEGMENTS),
    .SEG_AW   (SEG_AW)
  ) u_mem (
    .clk     (clk),
    .rst_n   (rst_n),
    .cmd     (mem_cmd),
    .rd_addr (rd_addr),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_data (rd_data)
  );

  // one divider per color, shared with position recompute
  for (genvar g = 0; g < 3; g++) begin : g_div
    sca_div u_div (
      .clk       (clk),
      .rst_n     (rst_n),
      .start     (div_start),
      .dividend  (div_dividend[g]),
      .divisor   (div_divisor[g]),
      .busy      (div_busy[g]),
      .quotient  (div_quo[g]),
      .remainder (div_rem[g])
    );
  end

  assign in_ready          = in_ready_c;
  assign out_valid         = out_valid_r;
  assign out_segment_index = out_idx_r;
  assign out_red_average   = out_red_r;
  assign out_green_average = out_green_r;
  assign out_blue_average  = out_blue_r;
  assign out_last_segment  = out_last_r;

endmodule

// ===== sv/sca_div.sv =====
`timescale 1ns / 1ps
module sca_div (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [sca_pkg::SUM_W-1:0]   dividend,
  input  logic [sca_pkg::COUNT_W-1:0] divisor,
  output logic                       busy,
  output logic [sca_pkg::SUM_W-1:0]   quotient,
  output logic [sca_pkg::COUNT_W-1:0] remainder
);
  import sca_pkg::*;

  localparam int CNT_W = $clog2(SUM_W);
  localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(SUM_W - 1);

  logic                busy_r;
  logic [CNT_W-1:0]    cnt_r;
  logic [SUM_W-1:0]    quo_r, quo_nxt;
  logic [COUNT_W-1:0]  rem_r, rem_nxt;
  logic [COUNT_W-1:0]  dvs_r;
  logic [COUNT_W:0]    shifted;
  logic [COUNT_W:0]    diff;

  // one restoring step: shift in the next dividend bit and try a subtract
  always_comb begin
    shifted = {rem_r, quo_r[SUM_W-1]};
    diff    = shifted - {1'b0, dvs_r};
    if (shifted >= {1'b0, dvs_r}) begin
      rem_nxt = diff[COUNT_W-1:0];
      quo_nxt = {quo_r[SUM_W-2:0], 1'b1};
    end else begin
      rem_nxt = shifted[COUNT_W-1:0];
      quo_nxt = {quo_r[SUM_W-2:0], 1'b0};
    end
  end

  // step counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= '0;
    end else if (busy_r) begin
      cnt_r <= cnt_r + 1'b1;
      if (cnt_r == LAST_STEP) begin
        busy_r <= 1'b0;
      end
    end
  end

  // operand and partial result registers
  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      rem_r <= '0;
      dvs_r <= divisor;
    end else if (busy_r) begin
      quo_r <= quo_nxt;
      rem_r <= rem_nxt;
    end
  end

  assign busy      = busy_r;
  assign quotient  = quo_r;
  assign remainder = rem_r;

endmodule

// ===== sv/sca_sum_mem.sv =====
`timescale 1ns / 1ps
module sca_sum_mem #(
  parameter int SEGMENTS = sca_pkg::SEGMENTS_DEF,
  parameter int SEG_AW   = 5
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  sca_pkg::sca_mem_cmd_t       cmd,
  input  logic [SEG_AW-1:0]           rd_addr,
  input  logic [SEG_AW-1:0]           wr_addr,
  input  logic [sca_pkg::WORD_W-1:0]  wr_data,
  output logic [sca_pkg::WORD_W-1:0]  rd_data
);
  import sca_pkg::*;

  logic [WORD_W-1:0]   mem [SEGMENTS];
  logic [SEGMENTS-1:0] valid_r;
  logic [WORD_W-1:0]   rd_word_r;
  logic                rd_valid_r;

  // entry valid bits, an invalid entry reads as zero
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r    <= '0;
      rd_valid_r <= 1'b0;
    end else begin
      if (cmd.rd_en) begin
        rd_valid_r <= valid_r[rd_addr];
      end
      if (cmd.wr_en) begin
        valid_r[wr_addr] <= 1'b1;
      end
      if (cmd.clr_en) begin
        valid_r[rd_addr] <= 1'b0;
      end
    end
  end

  // storage and registered read port
  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (cmd.rd_en) begin
      rd_word_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_valid_r ? rd_word_r : '0;

endmodule

// ===== sv/sca_checker.sv =====
`timescale 1ns / 1ps
`include "segment_color_averager_assert.svh"
module sca_checker #(
  parameter int SEGMENTS = sca_pkg::SEGMENTS_DEF
) (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         in_ready,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic [sca_pkg::SEG_IDX_W-1:0] out_segment_index,
  input logic [sca_pkg::COLOR_W-1:0]   out_red_average,
  input logic [sca_pkg::COLOR_W-1:0]   out_green_average,
  input logic [sca_pkg::COLOR_W-1:0]   out_blue_average,
  input logic                         out_last_segment
);
  import sca_pkg::*;

  localparam logic [SEG_IDX_W-1:0] LAST_IDX = SEG_IDX_W'(SEGMENTS - 1);

  // a stalled result holds
  `SCA_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_segment_index) && $stable(out_red_average) && $stable(out_green_average) && $stable(out_blue_average) && $stable(out_last_segment), "stalled result changed")

  // last flag only on the last segment
  `SCA_ASSERT_NOW(a_last_idx, clk, rst_n, out_valid, out_last_segment == (out_segment_index == LAST_IDX), "last flag and segment index disagree")

  // results come in segment order
  `SCA_ASSERT_NEXT(a_idx_order, clk, rst_n, out_valid && out_ready && !out_last_segment, !out_valid || (out_segment_index == SEG_IDX_W'($past(out_segment_index) + 1'b1)), "segment results out of order")

  // no pixels taken while a frame's results are still being formed
  `SCA_ASSERT_NOW(a_no_pixel_in_drain, clk, rst_n, out_valid && !out_last_segment, !in_ready, "pixel request accepted during result drain")

endmodule

bind segment_color_averager sca_checker #(
  .SEGMENTS (SEGMENTS)
) u_sca_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_ready          (in_ready),
  .out_valid         (out_valid),
  .out_ready         (out_ready),
  .out_segment_index (out_segment_index),
  .out_red_average   (out_red_average),
  .out_green_average (out_green_average),
  .out_blue_average  (out_blue_average),
  .out_last_segment  (out_last_segment)
);

// ===== dv/segment_average_checker.sv =====
`timescale 1ns / 1ps
module segment_average_checker #(
  parameter int SEGMENTS = sca_pkg::SEGMENTS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  input  logic                           in_ready,
  input  logic [sca_pkg::COLOR_W-1:0]    in_pixel_red,
  input  logic [sca_pkg::COLOR_W-1:0]    in_pixel_green,
  input  logic [sca_pkg::COLOR_W-1:0]    in_pixel_blue,
  input  logic                           in_start_of_frame,
  input  logic                           out_valid,
  input  logic                           out_ready,
  input  logic [sca_pkg::SEG_IDX_W-1:0]  out_segment_index,
  input  logic [sca_pkg::COLOR_W-1:0]    out_red_average,
  input  logic [sca_pkg::COLOR_W-1:0]    out_green_average,
  input  logic [sca_pkg::COLOR_W-1:0]    out_blue_average,
  input  logic                           out_last_segment,
  input  logic                           cfg_valid,
  input  logic                           cfg_ready,
  input  logic [sca_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [sca_pkg::CFG_DATA_W-1:0] cfg_data,
  output int                             mismatch_count,
  output int                             outstanding
);
  import sca_pkg::*;

  localparam int SHOWN_MISMATCHES = 10;

  typedef struct packed {
    logic [SEG_IDX_W-1:0] segment;
    logic [COLOR_W-1:0]   red;
    logic [COLOR_W-1:0]   green;
    logic [COLOR_W-1:0]   blue;
    logic                 last_seg;
  } segment_average_t;

  // register copies
  logic [FW_W-1:0]   frame_width_r;
  logic [FL_W-1:0]   frame_lines_r;
  logic [STEP_W-1:0] column_step_r;
  logic [STEP_W-1:0] row_step_r;
  logic [SW_W-1:0]   segment_width_r;

  // raster position and accumulators
  logic [COL_W-1:0]   col_pos;
  logic [LINE_W-1:0]  line_pos;
  logic [COUNT_W-1:0] seg0_count;
  logic [SUM_W-1:0]   red_sum   [SEGMENTS];
  logic [SUM_W-1:0]   green_sum [SEGMENTS];
  logic [SUM_W-1:0]   blue_sum  [SEGMENTS];

  segment_average_t averages_due[$];
  int mismatches = 0;

  function automatic logic [COLOR_W-1:0] average_of(logic [SUM_W-1:0] sum,
                                                    logic [COUNT_W-1:0] count);
    logic [SUM_W-1:0] quotient;
    if (count == '0) return '0;
    quotient = sum / count;
    // saturate when a segment saw more samples than segment 0
    if (quotient > {COLOR_W{1'b1}}) return '1;
    return quotient[COLOR_W-1:0];
  endfunction

  function automatic int unsigned at_least_one(int unsigned v);
    return (v == 0) ? 1 : v;
  endfunction

  task automatic clear_sums();
    seg0_count = '0;
    foreach (red_sum[i]) begin
      red_sum[i]   = '0;
      green_sum[i] = '0;
      blue_sum[i]  = '0;
    end
  endtask

  task automatic flag_result(string detail);
    mismatches++;
    if (mismatches <= SHOWN_MISMATCHES)
      $display("mismatch at %0t ns: %s", $time, detail);
  endtask

  task automatic apply_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    case (idx)
      REG_FRAME_WIDTH:   frame_width_r   = data[FW_W-1:0];
      REG_FRAME_LINES:   frame_lines_r   = data[FL_W-1:0];
      REG_COLUMN_STEP:   column_step_r   = data[STEP_W-1:0];
      REG_ROW_STEP:      row_step_r      = data[STEP_W-1:0];
      REG_SEGMENT_WIDTH: segment_width_r = data[SW_W-1:0];
      default: ;
    endcase
  endtask

  // one pixel through the accumulator, frame end queues one average per segment
  task automatic absorb_pixel(logic [COLOR_W-1:0] red, logic [COLOR_W-1:0] green,
                              logic [COLOR_W-1:0] blue, logic sof);
    int unsigned width, lines, cstep, rstep, swidth, seg;
    bit line_end, frame_end;
    segment_average_t res;
    width  = at_least_one(32'(frame_width_r));
    lines  = at_least_one(32'(frame_lines_r));
    cstep  = at_least_one(32'(column_step_r));
    rstep  = at_least_one(32'(row_step_r));
    swidth = at_least_one(32'(segment_width_r));
    if (width > 32'(MAX_WIDTH)) width = 32'(MAX_WIDTH);

    if (sof) begin
      col_pos  = '0;
      line_pos = '0;
    end

    if (line_pos % rstep == 0 && col_pos % cstep == 0) begin
      seg = col_pos / swidth;
      if (seg > SEGMENTS - 1) seg = SEGMENTS - 1;
      if (seg == 0) seg0_count = seg0_count + 1'b1;
      red_sum[seg]   = red_sum[seg] + red;
      green_sum[seg] = green_sum[seg] + green;
      blue_sum[seg]  = blue_sum[seg] + blue;
    end

    line_end  = (col_pos + 1 >= width);
    frame_end = line_end && (line_pos + 1 >= lines);

    if (!frame_end) begin
      if (line_end) begin
        col_pos  = '0;
        line_pos = line_pos + 1'b1;
      end else begin
        col_pos = col_pos + 1'b1;
      end
    end else begin
      for (int i = 0; i < SEGMENTS; i++) begin
        res.segment  = SEG_IDX_W'(i);
        res.red      = average_of(red_sum[i], seg0_count);
        res.green    = average_of(green_sum[i], seg0_count);
        res.blue     = average_of(blue_sum[i], seg0_count);
        res.last_seg = (i == SEGMENTS - 1);
        averages_due.push_back(res);
      end
      clear_sums();
      col_pos  = '0;
      line_pos = '0;
    end
  endtask

  task automatic check_average();
    segment_average_t want;
    if (averages_due.size() == 0) begin
      flag_result($sformatf("unexpected result idx %0d rgb %0d/%0d/%0d last %0b",
                            out_segment_index, out_red_average, out_green_average,
                            out_blue_average, out_last_segment));
      return;
    end
    want = averages_due.pop_front();
    if (out_segment_index !== want.segment || out_red_average !== want.red ||
        out_green_average !== want.green || out_blue_average !== want.blue ||
        out_last_segment !== want.last_seg)
      flag_result($sformatf({"expected idx %0d rgb %0d/%0d/%0d last %0b, ",
                             "got idx %0d rgb %0d/%0d/%0d last %0b"},
                            want.segment, want.red, want.green, want.blue, want.last_seg,
                            out_segment_index, out_red_average, out_green_average,
                            out_blue_average, out_last_segment));
  endtask

  // watch all three channels at the clock edge
  always @(posedge clk) begin
    if (!rst_n) begin
      frame_width_r   = FW_RST;
      frame_lines_r   = FL_RST;
      column_step_r   = CSTEP_RST;
      row_step_r      = RSTEP_RST;
      segment_width_r = SW_RST;
      col_pos         = '0;
      line_pos        = '0;
      clear_sums();
      averages_due.delete();
    end else begin
      if (out_valid && out_ready) check_average();
      if (cfg_valid && cfg_ready) apply_register(cfg_index, cfg_data);
      if (in_valid && in_ready)
        absorb_pixel(in_pixel_red, in_pixel_green, in_pixel_blue, in_start_of_frame);
    end
    mismatch_count <= mismatches;
    outstanding    <= averages_due.size();
  end

endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 1ps
module tb;
  import sca_pkg::*;

  localparam int RANDOM_ITEMS = 86;
  localparam int WAIT_MAX     = 18;
  localparam int DRAIN_CYCLES = 64;
  localparam int STALL_LIMIT  = 2000;
  localparam int STEP_PAD     = CFG_DATA_W - STEP_W;
  localparam int LINES_PAD    = CFG_DATA_W - FL_W;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic [COLOR_W-1:0]    in_pixel_red = '0;
  logic [COLOR_W-1:0]    in_pixel_green = '0;
  logic [COLOR_W-1:0]    in_pixel_blue = '0;
  logic                  in_start_of_frame = 1'b0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [SEG_IDX_W-1:0]  out_segment_index;
  logic [COLOR_W-1:0]    out_red_average;
  logic [COLOR_W-1:0]    out_green_average;
  logic [COLOR_W-1:0]    out_blue_average;
  logic                  out_last_segment;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  int mismatch_count;
  int outstanding;
  int idle_cycles = 0;
  int send_calm = 0;
  int take_calm = 0;

  segment_color_averager DUT (.*);

  segment_average_checker averages_chk (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // wait per request, with runs of back-to-back traffic
  function automatic int pick_wait(inout int calm);
    if (calm > 0) begin
      calm--;
      return 0;
    end
    if ($urandom_range(0, 19) == 0) calm = $urandom_range(8, 40);
    return $urandom_range(0, WAIT_MAX);
  endfunction

  function automatic logic [COLOR_W-1:0] pick_color();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      default: return COLOR_W'($urandom);
    endcase
  endfunction

  task automatic push_pixel(input logic [COLOR_W-1:0] red, input logic [COLOR_W-1:0] green,
                            input logic [COLOR_W-1:0] blue, input logic sof);
    int gap;
    gap = pick_wait(send_calm);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid          <= 1'b1;
    in_pixel_red      <= red;
    in_pixel_green    <= green;
    in_pixel_blue     <= blue;
    in_start_of_frame <= sof;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  // full register set, plus a write to an unused index
  task automatic load_setup(input logic [CFG_DATA_W-1:0] fw, input logic [CFG_DATA_W-1:0] fl,
                            input logic [CFG_DATA_W-1:0] cs, input logic [CFG_DATA_W-1:0] rs,
                            input logic [CFG_DATA_W-1:0] sw);
    write_reg(REG_FRAME_WIDTH, fw);
    write_reg(REG_FRAME_LINES, fl);
    write_reg(REG_COLUMN_STEP, cs);
    write_reg(REG_ROW_STEP, rs);
    write_reg(REG_SEGMENT_WIDTH, sw);
    write_reg(CFG_IDX_W'($urandom_range(REG_SEGMENT_WIDTH + 1, (1 << CFG_IDX_W) - 1)),
              CFG_DATA_W'($urandom));
    cfg_valid <= 1'b0;
  endtask

  // drain all expected averages, then let the block go quiet
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // result side backpressure
  initial begin
    wait (rst_n);
    @(posedge clk);
    forever begin
      int stall;
      stall = pick_wait(take_calm);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  // watchdog on cycles without any request
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    logic [FW_W-1:0]      fw;
    logic [FL_W-1:0]      fl;
    logic [STEP_W-1:0]    cs;
    logic [STEP_W-1:0]    rs;
    logic [SW_W-1:0]      sw;
    logic [LINES_PAD-1:0] fl_pad;
    logic [STEP_PAD-1:0]  cs_pad;
    logic [STEP_PAD-1:0]  rs_pad;
    int span;
    int frames;
    int count;
    int random_items;

    random_items = 0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // one pixel under the reset register values
    push_pixel('1, '1, '1, 1'b1);

    // large values, oversized width
    settle();
    load_setup(CFG_DATA_W'(8191), CFG_DATA_W'(2047), CFG_DATA_W'(64), CFG_DATA_W'(64),
               CFG_DATA_W'(4096));
    push_pixel('0, '0, '0, 1'b0);

    // zero registers act as one, position is past the region so the frame ends
    settle();
    load_setup('0, '0, '0, '0, '0);
    push_pixel(pick_color(), pick_color(), pick_color(), 1'b0);

    // one-column segments: mid-frame restart, clamped last segment saturates
    settle();
    load_setup(CFG_DATA_W'(22), CFG_DATA_W'(1), CFG_DATA_W'(1), CFG_DATA_W'(1),
               CFG_DATA_W'(1));
    push_pixel(pick_color(), pick_color(), pick_color(), 1'b1);
    push_pixel(pick_color(), pick_color(), pick_color(), 1'b1);
    for (int c = 1; c < 22; c++) begin
      if (c >= averages_chk.SEGMENTS - 1)
        push_pixel('1, '1, '1, 1'b0);
      else
        push_pixel(pick_color(), pick_color(), pick_color(), 1'b0);
    end

    // random small frames, mostly whole ones
    while (random_items < RANDOM_ITEMS) begin
      settle();
      case ($urandom_range(0, 9))
        0: fw = '0;
        1, 2: fw = FW_W'($urandom_range(20, 26));
        default: fw = FW_W'($urandom_range(1, 8));
      endcase
      fl = ($urandom_range(0, 9) == 0) ? '0 : FL_W'($urandom_range(1, 3));
      case ($urandom_range(0, 9))
        0: cs = '0;
        1: cs = STEP_W'($urandom_range(5, 64));
        default: cs = STEP_W'($urandom_range(1, 4));
      endcase
      case ($urandom_range(0, 9))
        0: rs = '0;
        1: rs = STEP_W'($urandom_range(4, 64));
        default: rs = STEP_W'($urandom_range(1, 3));
      endcase
      case ($urandom_range(0, 9))
        0: sw = '0;
        1: sw = SW_W'($urandom_range(7, 4096));
        default: sw = SW_W'($urandom_range(1, 6));
      endcase
      // unused upper data bits must be dropped by the block
      fl_pad = ($urandom_range(0, 3) == 0) ? LINES_PAD'($urandom) : '0;
      cs_pad = ($urandom_range(0, 3) == 0) ? STEP_PAD'($urandom) : '0;
      rs_pad = ($urandom_range(0, 3) == 0) ? STEP_PAD'($urandom) : '0;
      load_setup(fw, {fl_pad, fl}, {cs_pad, cs}, {rs_pad, rs}, sw);

      span   = ((fw == 0) ? 1 : int'(fw)) * ((fl == 0) ? 1 : int'(fl));
      frames = (span > 30) ? 1 : $urandom_range(1, 3);
      repeat (frames) begin
        count = span;
        if ($urandom_range(0, 7) == 0) count = $urandom_range(1, span);
        for (int p = 0; p < count; p++) begin
          if (p == 0)
            push_pixel(pick_color(), pick_color(), pick_color(), $urandom_range(0, 3) != 0);
          else
            push_pixel(pick_color(), pick_color(), pick_color(), $urandom_range(0, 39) == 0);
          random_items++;
        end
      end
    end

    settle();
    if (mismatch_count == 0 && outstanding == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule
